[rtl/bitmap_frame_allocator_unit_macros.svh]
// Assertion macros for the frame allocator modules, used by bfa_back.
// Each one expects clk and rst_n to be visible where it is used.
`ifndef BITMAP_FRAME_ALLOCATOR_UNIT_MACROS_SVH
`define BITMAP_FRAME_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BFA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BFA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/bfa_pkg.sv]
package bfa_pkg;

  localparam int FRAME_W = 6;
  localparam int COUNT_W = 7;

  localparam logic [1:0] MODE_ALLOC   = 2'd0;
  localparam logic [1:0] MODE_BATCH   = 2'd1;
  localparam logic [1:0] MODE_RELEASE = 2'd2;
  localparam logic [1:0] MODE_IGNORED = 2'd3;

  localparam logic [1:0] STATUS_GRANTED  = 2'd0;
  localparam logic [1:0] STATUS_NO_SPACE = 2'd1;
  localparam logic [1:0] STATUS_RELEASED = 2'd2;
  localparam logic [1:0] STATUS_EMPTY    = 2'd3;

  typedef struct packed {
    logic [1:0]         mode;
    logic               use_random;
    logic [FRAME_W-1:0] random_start;
    logic [COUNT_W-1:0] request_count;
    logic [FRAME_W-1:0] release_index;
  } bfa_in_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_number;
    logic [1:0]         status;
    logic [COUNT_W-1:0] free_frames;
    logic               last_of_run;
  } bfa_out_t;

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_BATCH,
    OP_EMPTY,
    OP_RELEASE
  } bfa_op_t;

  // Decoded command handed from the front end to the engine.
  typedef struct packed {
    bfa_op_t            op;
    logic               use_random;
    logic [FRAME_W-1:0] start;
    logic [COUNT_W-1:0] count;
    logic [FRAME_W-1:0] index;
    logic               index_ok;
  } bfa_cmd_t;

  // Lowest set bit of a 64-bit word, found a byte at a time.
  function automatic logic [FRAME_W-1:0] bfa_lowest_set(input logic [63:0] v);
    logic [7:0] any;
    logic [2:0] grp;
    logic [7:0] byte_v;
    logic [2:0] bit_pos;
    for (int g = 0; g < 8; g++) begin
      any[g] = |v[g*8 +: 8];
    end
    grp = 3'd0;
    for (int g = 7; g >= 0; g--) begin
      if (any[g]) begin
        grp = 3'(g);
      end
    end
    byte_v  = v[grp*8 +: 8];
    bit_pos = 3'd0;
    for (int b = 7; b >= 0; b--) begin
      if (byte_v[b]) begin
        bit_pos = 3'(b);
      end
    end
    return {grp, bit_pos};
  endfunction

endpackage

[rtl/bfa_front.sv]
module bfa_front
  import bfa_pkg::*;
#(
  parameter int NUM_FRAMES = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  bfa_in_t  in_data,
  output logic     cmd_valid,
  input  logic     cmd_ready,
  output bfa_cmd_t cmd_data
);

  localparam int QDEPTH = 2;

  logic [FRAME_W-1:0] mod_tab [64];
  bfa_cmd_t           cmd_new;
  logic               push;
  logic               pop;

  bfa_cmd_t   q_r [QDEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  // Start index reduced modulo the frame count, worked out at elaboration.
  for (genvar g = 0; g < 64; g++) begin : g_mod
    assign mod_tab[g] = FRAME_W'(g % NUM_FRAMES);
  end

  always_comb begin
    cmd_new.use_random = in_data.use_random;
    cmd_new.start      = in_data.use_random ? mod_tab[in_data.random_start] : '0;
    cmd_new.count      = in_data.request_count;
    cmd_new.index      = in_data.release_index;
    cmd_new.index_ok   = COUNT_W'(in_data.release_index) < COUNT_W'(NUM_FRAMES);
    case (in_data.mode)
      MODE_ALLOC:   cmd_new.op = OP_ALLOC;
      MODE_BATCH:   cmd_new.op = (in_data.request_count == '0) ? OP_EMPTY : OP_BATCH;
      MODE_RELEASE: cmd_new.op = OP_RELEASE;
      default:      cmd_new.op = OP_RELEASE;
    endcase
  end

  // The unused mode code is taken and dropped without queueing anything.
  assign in_ready  = (cnt_r != 2'(QDEPTH));
  assign push      = in_valid && in_ready && (in_data.mode != MODE_IGNORED);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd_data  = q_r[rd_ptr_r];
  assign pop       = cmd_valid && cmd_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cmd_new;
    end
  end

endmodule

[rtl/bfa_back.sv]
`include "bitmap_frame_allocator_unit_macros.svh"

module bfa_back
  import bfa_pkg::*;
#(
  parameter int NUM_FRAMES = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cmd_valid,
  output logic     cmd_ready,
  input  bfa_cmd_t cmd_data,
  output logic     out_valid,
  input  logic     out_ready,
  output bfa_out_t out_data
);

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_BATCH = 2'b10
  } bfa_state_t;

  bfa_state_t         state_r, state_nxt;
  logic [NUM_FRAMES-1:0] used_r, used_nxt;
  logic [COUNT_W-1:0] free_r, free_nxt;
  logic [COUNT_W-1:0] left_r, left_nxt;
  logic [FRAME_W-1:0] probe_r, probe_nxt;
  logic               rnd_r, rnd_nxt;
  logic               out_valid_r, out_valid_nxt;
  bfa_out_t           out_r, out_nxt;

  logic               slot;
  logic [FRAME_W-1:0] start_sel;
  logic [63:0]        free_vec;
  logic [63:0]        free_hi;
  logic [FRAME_W-1:0] pick;
  logic [FRAME_W-1:0] pick_next;
  logic [NUM_FRAMES-1:0] pick_bit;
  logic [NUM_FRAMES-1:0] rel_bit;

  assign slot      = !out_valid_r || out_ready;
  assign cmd_ready = (state_r == S_IDLE) && slot;
  assign start_sel = (state_r == S_IDLE) ? cmd_data.start : probe_r;

  // Probe upward from the start, wrapping to the lowest free frame.
  assign free_vec  = 64'(~used_r);
  assign free_hi   = free_vec & (~64'd0 << start_sel);
  assign pick      = (free_hi != '0) ? bfa_lowest_set(free_hi) : bfa_lowest_set(free_vec);
  assign pick_next = (pick == FRAME_W'(NUM_FRAMES - 1)) ? '0 : pick + 1'b1;
  assign pick_bit  = NUM_FRAMES'(64'd1 << pick);
  assign rel_bit   = NUM_FRAMES'(64'd1 << cmd_data.index);

  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    free_nxt      = free_r;
    left_nxt      = left_r;
    probe_nxt     = probe_r;
    rnd_nxt       = rnd_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    case (state_r)
      S_IDLE: begin
        if (cmd_valid && slot) begin
          out_valid_nxt = 1'b1;
          out_nxt.last_of_run = 1'b1;
          out_nxt.frame_number = '0;
          case (cmd_data.op)
            OP_ALLOC: begin
              if (free_r == '0) begin
                out_nxt.status      = STATUS_NO_SPACE;
                out_nxt.free_frames = free_r;
              end else begin
                used_nxt             = used_r | pick_bit;
                free_nxt             = free_r - 1'b1;
                out_nxt.frame_number = pick;
                out_nxt.status       = STATUS_GRANTED;
                out_nxt.free_frames  = free_r - 1'b1;
              end
            end
            OP_BATCH: begin
              if (cmd_data.count > free_r) begin
                out_nxt.status      = STATUS_NO_SPACE;
                out_nxt.free_frames = free_r;
              end else begin
                used_nxt             = used_r | pick_bit;
                free_nxt             = free_r - 1'b1;
                out_nxt.frame_number = pick;
                out_nxt.status       = STATUS_GRANTED;
                out_nxt.free_frames  = free_r - 1'b1;
                out_nxt.last_of_run  = (cmd_data.count == COUNT_W'(1));
                left_nxt             = cmd_data.count - 1'b1;
                rnd_nxt              = cmd_data.use_random;
                probe_nxt            = cmd_data.use_random ? pick_next : '0;
                if (cmd_data.count != COUNT_W'(1)) begin
                  state_nxt = S_BATCH;
                end
              end
            end
            OP_EMPTY: begin
              out_nxt.status      = STATUS_EMPTY;
              out_nxt.free_frames = free_r;
            end
            OP_RELEASE: begin
              out_nxt.status      = STATUS_RELEASED;
              out_nxt.free_frames = free_r;
              if (cmd_data.index_ok && ((used_r & rel_bit) != '0)) begin
                used_nxt            = used_r & ~rel_bit;
                free_nxt            = free_r + 1'b1;
                out_nxt.free_frames = free_r + 1'b1;
              end
            end
            default: begin
              out_valid_nxt = out_valid_r && !out_ready;
              out_nxt       = out_r;
            end
          endcase
        end
      end
      S_BATCH: begin
        if (slot) begin
          used_nxt             = used_r | pick_bit;
          free_nxt             = free_r - 1'b1;
          left_nxt             = left_r - 1'b1;
          probe_nxt            = rnd_r ? pick_next : '0;
          out_valid_nxt        = 1'b1;
          out_nxt.frame_number = pick;
          out_nxt.status       = STATUS_GRANTED;
          out_nxt.free_frames  = free_r - 1'b1;
          out_nxt.last_of_run  = (left_r == COUNT_W'(1));
          if (left_r == COUNT_W'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      free_r      <= COUNT_W'(NUM_FRAMES);
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      free_r      <= free_nxt;
      left_r      <= left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    probe_r <= probe_nxt;
    rnd_r   <= rnd_nxt;
    out_r   <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `BFA_ASSERT_IMP(a_count_matches_map, 1'b1,
    (COUNT_W'($countones(used_r)) + free_r) == COUNT_W'(NUM_FRAMES),
    "free count disagrees with the bitmap")
  `BFA_ASSERT_IMP(a_batch_has_work, state_r == S_BATCH, left_r != '0,
    "batch state entered with nothing left to grant")
  `BFA_ASSERT_IMP(a_grant_in_range, out_valid_r && (out_r.status == STATUS_GRANTED),
    COUNT_W'(out_r.frame_number) < COUNT_W'(NUM_FRAMES),
    "granted frame lies beyond the frame count")
  `BFA_ASSERT_NXT(a_grant_marks_used, (state_r == S_BATCH) && slot,
    (used_r != $past(used_r)) && (free_r == $past(free_r) - 1'b1),
    "batch grant did not take a free frame")

endmodule

[rtl/bitmap_frame_allocator_unit.sv]
// Channel  Direction  Payload    Transfer when
// in_      input      bfa_in_t   in_valid && in_ready
// out_     output     bfa_out_t  out_valid && out_ready
//
// A request passes a two-entry command queue, whose registered entry the allocation engine
// takes once it is idle; the engine then produces one result per cycle while the output
// is not stalled, and a batch keeps it busy until its last frame is granted.
// The engine's bitmap search and update is the step that sets this pace.
// Reset leaves every frame free; no clearing pass is needed.
// A stalled result holds in the output register while the queue keeps taking requests until its two entries are full.
module bitmap_frame_allocator_unit
  import bfa_pkg::*;
#(
  parameter int NUM_FRAMES = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  bfa_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output bfa_out_t out_data
);

  logic     cmd_valid;
  logic     cmd_ready;
  bfa_cmd_t cmd_data;

  bfa_front #(
    .NUM_FRAMES(NUM_FRAMES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd_data (cmd_data)
  );

  bfa_back #(
    .NUM_FRAMES(NUM_FRAMES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd_data (cmd_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

[test/testbench.sv]
module testbench;
  import bfa_pkg::*;

  localparam int NUM_FRAMES   = 64;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS  = 10;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  bfa_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  bfa_out_t out_data;

  // Shadow allocation state, updated as each request transfer is accepted.
  logic [NUM_FRAMES-1:0] frame_in_use;
  int                    free_count;
  bfa_out_t              pending_grants[$];

  int mismatch_count;
  int burst_left;
  int hold_request;
  int hold_left;
  int rx_style;
  int rx_phase;
  int cycle_count;

  bitmap_frame_allocator_unit #(
    .NUM_FRAMES(NUM_FRAMES)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  function automatic logic [FRAME_W-1:0] first_free_from(input logic [FRAME_W-1:0] start);
    logic [FRAME_W-1:0] f;
    f = start;
    for (int i = 0; i < NUM_FRAMES; i++) begin
      if (!frame_in_use[f]) begin
        return f;
      end
      f = f + 1'b1;  // wraps at the top of the frame range
    end
    return '0;
  endfunction

  function automatic logic [FRAME_W-1:0] pick_used_frame();
    logic [FRAME_W-1:0] f;
    f = FRAME_W'($urandom_range(0, NUM_FRAMES - 1));
    for (int i = 0; i < NUM_FRAMES; i++) begin
      if (frame_in_use[f]) begin
        return f;
      end
      f = f + 1'b1;
    end
    return f;
  endfunction

  function automatic bfa_in_t make_req(input logic [1:0] mode, input logic rnd,
                                       input logic [FRAME_W-1:0] start,
                                       input logic [COUNT_W-1:0] count,
                                       input logic [FRAME_W-1:0] index);
    bfa_in_t r;
    r.mode          = mode;
    r.use_random    = rnd;
    r.random_start  = start;
    r.request_count = count;
    r.release_index = index;
    return r;
  endfunction

  function automatic bfa_in_t noisy_req(input logic [1:0] mode);
    return make_req(mode, 1'($urandom_range(0, 1)), FRAME_W'($urandom_range(0, 63)),
                    COUNT_W'($urandom_range(0, 127)), FRAME_W'($urandom_range(0, 63)));
  endfunction

  // Mostly frees a frame that is really in use, now and then an arbitrary one.
  function automatic bfa_in_t release_req();
    bfa_in_t r;
    r = noisy_req(MODE_RELEASE);
    if ($urandom_range(0, 7) != 0) begin
      r.release_index = pick_used_frame();
    end
    return r;
  endfunction

  task automatic push_grant(input logic [FRAME_W-1:0] frame, input logic [1:0] status,
                            input logic last);
    bfa_out_t res;
    res.frame_number = frame;
    res.status       = status;
    res.free_frames  = COUNT_W'(free_count);
    res.last_of_run  = last;
    pending_grants.push_back(res);
  endtask

  task automatic predict_grants(input bfa_in_t req);
    logic [FRAME_W-1:0] probe;
    logic [FRAME_W-1:0] f;
    int                 wanted;
    wanted = int'(req.request_count);
    case (req.mode)
      MODE_ALLOC: begin
        if (free_count == 0) begin
          push_grant('0, STATUS_NO_SPACE, 1'b1);
        end else begin
          f = first_free_from(req.use_random ? req.random_start : '0);
          frame_in_use[f] = 1'b1;
          free_count--;
          push_grant(f, STATUS_GRANTED, 1'b1);
        end
      end
      MODE_BATCH: begin
        if (wanted == 0) begin
          push_grant('0, STATUS_EMPTY, 1'b1);
        end else if (wanted > free_count) begin
          push_grant('0, STATUS_NO_SPACE, 1'b1);
        end else begin
          // A random batch probes from the random start, then each further frame from just past the previous grant.
          probe = req.random_start;
          for (int k = 0; k < wanted; k++) begin
            f = first_free_from(req.use_random ? probe : '0);
            frame_in_use[f] = 1'b1;
            free_count--;
            push_grant(f, STATUS_GRANTED, k == wanted - 1);
            probe = f + 1'b1;
          end
        end
      end
      MODE_RELEASE: begin
        if (int'(req.release_index) < NUM_FRAMES && frame_in_use[req.release_index]) begin
          frame_in_use[req.release_index] = 1'b0;
          free_count++;
        end
        push_grant('0, STATUS_RELEASED, 1'b1);
      end
      default: begin
      end
    endcase
  endtask

  task automatic note_failure(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%s", what);
    end
  endtask

  // Offers one request, with random gaps between bursts, and predicts its
  // results once the transfer has happened.
  task automatic send_request(input bfa_in_t req);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 10);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    predict_grants(req);
  endtask

  // Always waits on the clock before it checks, so the valid drop lands in its own step.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_grants.size() != 0);
  endtask

  task automatic test_edge_requests();
    send_request(make_req(MODE_IGNORED, 1'b1, 6'd21, 7'd5, 6'd9));
    send_request(make_req(MODE_BATCH, 1'b0, 6'd0, 7'd0, 6'd0));
    send_request(make_req(MODE_BATCH, 1'b1, 6'd63, 7'd127, 6'd63));
    send_request(make_req(MODE_BATCH, 1'b0, 6'd0, 7'd65, 6'd0));
    send_request(make_req(MODE_ALLOC, 1'b0, 6'd40, 7'd0, 6'd0));
    send_request(make_req(MODE_ALLOC, 1'b1, 6'd63, 7'd0, 6'd0));
    send_request(make_req(MODE_RELEASE, 1'b0, 6'd0, 7'd0, 6'd0));
    // Freeing a frame that is already free changes nothing.
    send_request(make_req(MODE_RELEASE, 1'b0, 6'd0, 7'd0, 6'd0));
    // This batch takes every remaining frame and wraps past the top.
    send_request(make_req(MODE_BATCH, 1'b1, 6'd62, 7'd63, 6'd0));
    send_request(make_req(MODE_ALLOC, 1'b0, 6'd0, 7'd0, 6'd0));
    send_request(make_req(MODE_ALLOC, 1'b1, 6'd17, 7'd0, 6'd0));
    send_request(make_req(MODE_BATCH, 1'b0, 6'd0, 7'd1, 6'd0));
    send_request(make_req(MODE_BATCH, 1'b1, 6'd3, 7'd0, 6'd0));
    send_request(make_req(MODE_RELEASE, 1'b0, 6'd0, 7'd0, 6'd5));
    send_request(make_req(MODE_RELEASE, 1'b0, 6'd0, 7'd0, 6'd40));
    send_request(make_req(MODE_RELEASE, 1'b0, 6'd0, 7'd0, 6'd10));
    send_request(make_req(MODE_BATCH, 1'b1, 6'd41, 7'd3, 6'd0));
    send_request(make_req(MODE_RELEASE, 1'b0, 6'd0, 7'd0, 6'd63));
    send_request(make_req(MODE_RELEASE, 1'b0, 6'd0, 7'd0, 6'd2));
    send_request(make_req(MODE_BATCH, 1'b0, 6'd50, 7'd2, 6'd0));
    send_request(make_req(MODE_RELEASE, 1'b1, 6'd0, 7'd0, 6'd63));
    send_request(make_req(MODE_ALLOC, 1'b1, 6'd63, 7'd0, 6'd0));
    send_request(make_req(MODE_RELEASE, 1'b0, 6'd0, 7'd0, 6'd7));
    send_request(make_req(MODE_IGNORED, 1'b0, 6'd0, 7'd127, 6'd63));
    send_request(make_req(MODE_ALLOC, 1'b1, 6'd0, 7'd0, 6'd0));
    wait_drained();
  endtask

  task automatic test_single_frames();
    int release_odds;
    for (int i = 0; i < 100; i++) begin
      release_odds = (free_count < 16) ? 3 : (free_count > 48) ? 1 : 2;
      if ($urandom_range(0, 3) < release_odds) begin
        send_request(release_req());
      end else begin
        send_request(noisy_req(MODE_ALLOC));
      end
    end
  endtask

  task automatic test_batches();
    bfa_in_t req;
    int      pick;
    for (int i = 0; i < 80; i++) begin
      if (free_count < 16) begin
        send_request(release_req());
      end else begin
        req  = noisy_req(MODE_BATCH);
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          req.request_count = COUNT_W'($urandom_range(1, 6));
        end else if (pick == 7) begin
          req.request_count = '0;
        end else if (pick == 8) begin
          req.request_count = COUNT_W'(free_count);
        end else begin
          req.request_count = COUNT_W'($urandom_range(free_count + 1, 127));
        end
        send_request(req);
      end
    end
  endtask

  // The receiver holds off while requests keep coming, so the block fills
  // up and has to refuse further transfers for a while.
  task automatic test_backpressure();
    bfa_in_t req;
    wait_drained();
    hold_request = 300;
    for (int i = 0; i < 40; i++) begin
      if (i % 3 == 0) begin
        send_request(release_req());
      end else if (i % 3 == 1) begin
        send_request(noisy_req(MODE_ALLOC));
      end else begin
        req = noisy_req(MODE_BATCH);
        req.request_count = COUNT_W'($urandom_range(1, 4));
        send_request(req);
      end
    end
    wait_drained();
  endtask

  task automatic test_mixed_traffic();
    bfa_in_t req;
    int      pick;
    for (int i = 0; i < 200; i++) begin
      pick = $urandom_range(0, 19);
      if (pick < 7) begin
        send_request(noisy_req(MODE_ALLOC));
      end else if (pick < 11) begin
        req = noisy_req(MODE_BATCH);
        if ($urandom_range(0, 3) != 0) begin
          req.request_count = COUNT_W'($urandom_range(0, 8));
        end
        send_request(req);
      end else if (pick < 19) begin
        send_request(release_req());
      end else begin
        send_request(noisy_req(MODE_IGNORED));
      end
    end
  endtask

  // Receiver: a stall pattern whose style is redrawn whenever its phase counter wraps,
  // overridden by a long hold-off when one is asked for.
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (rx_phase == 0) begin
      rx_style = $urandom_range(0, 3);
    end
    rx_phase = (rx_phase + 1) % 48;
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (rx_style)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        2:       out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= (rx_phase % 5) < 3;
      endcase
    end
  end

  always @(posedge clk) begin
    bfa_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_grants.size() == 0) begin
        note_failure($sformatf("unexpected result: frame %0d status %0d free %0d last %0b",
                               out_data.frame_number, out_data.status,
                               out_data.free_frames, out_data.last_of_run));
      end else begin
        want = pending_grants.pop_front();
        if (out_data.frame_number !== want.frame_number || out_data.status !== want.status ||
            out_data.free_frames !== want.free_frames ||
            out_data.last_of_run !== want.last_of_run) begin
          note_failure($sformatf({"result mismatch: expected frame %0d status %0d free %0d ",
                                  "last %0b, got frame %0d status %0d free %0d last %0b"},
                                 want.frame_number, want.status, want.free_frames,
                                 want.last_of_run, out_data.frame_number, out_data.status,
                                 out_data.free_frames, out_data.last_of_run));
        end
      end
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_ready      = 1'b0;
    frame_in_use   = '0;
    free_count     = NUM_FRAMES;
    mismatch_count = 0;
    burst_left     = 0;
    hold_request   = 0;
    hold_left      = 0;
    rx_style       = 0;
    rx_phase       = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_edge_requests();
    test_single_frames();
    test_batches();
    test_backpressure();
    test_mixed_traffic();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    mismatch_count += pending_grants.size();
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
